// ----- hw/rtl/bxf_pkg.sv -----
// ----------------------------------------------------------------------------
// bxf_pkg
// Shared constants, types and the reciprocal table of the box mean filter.
// ----------------------------------------------------------------------------
package bxf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_WINDOW_DEF = 11;
  localparam int CHANNELS_DEF   = 3;

  // pixel samples and channels carried on the stream ports
  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int PORT_CH = 3;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 12;
  localparam int WS_W      = 4;
  localparam int LW_W      = 12;
  localparam logic [WS_W-1:0] WS_RESET = 4'd3;
  localparam logic [LW_W-1:0] LW_RESET = 12'd640;
  localparam int WIN_MIN   = 3;

  // widths for clamping the register values against the parameters
  localparam int WIN_CMP_W = 5;
  localparam int WID_CMP_W = 14;

  // mean = (sum * recip) >> RECIP_SHIFT, exact for sums below 2^18 and d up to 31
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_LINE_WIDTH  = 1'b1
  } bxf_reg_t;

  // per-beat control that travels beside the lane data
  typedef struct packed {
    logic valid;
    logic first_row;
    logic full;
    logic col0;
    logic emit;
    logic last;
  } bxf_ctl_t;

  // ceil(2^RECIP_SHIFT / (d*d)) for odd window sides
  function automatic logic [RECIP_W-1:0] recip_for(input logic [WIN_CMP_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      5'd3:    r = 25'd29826162;
      5'd5:    r = 25'd10737419;
      5'd7:    r = 25'd5478275;
      5'd9:    r = 25'd3314018;
      5'd11:   r = 25'd2218475;
      5'd13:   r = 25'd1588376;
      5'd15:   r = 25'd1193047;
      5'd17:   r = 25'd928843;
      5'd19:   r = 25'd743589;
      5'd21:   r = 25'd608698;
      5'd23:   r = 25'd507440;
      5'd25:   r = 25'd429497;
      5'd27:   r = 25'd368225;
      5'd29:   r = 25'd319187;
      5'd31:   r = 25'd279330;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/bxf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bxf_ctrl
// Configuration registers, raster position counters and the control pipe.
// ----------------------------------------------------------------------------
module bxf_ctrl import bxf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int SW = $clog2(MAX_WINDOW - 1),
  localparam int DW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic                 frame_start,
  input  logic                 adv,
  output logic [CW-1:0]        col,
  output logic [SW-1:0]        slot,
  output logic [DW-1:0]        dm1,
  output logic [RECIP_W-1:0]   recip,
  output bxf_ctl_t             ctl1,
  output bxf_ctl_t             ctl3
);

  logic [WS_W-1:0]      window_size;
  logic [LW_W-1:0]      line_width;
  logic [CW-1:0]        column_count, column_count_next;
  logic [DW-1:0]        row_count, row_count_next;
  logic [SW-1:0]        slot_ptr, slot_ptr_next;
  logic [WIN_CMP_W-1:0] d_cl;
  logic [DW-1:0]        d_eff;
  logic [WID_CMP_W-1:0] w_cl;
  logic [CW:0]          w_eff;
  logic [CW-1:0]        cc_b;
  logic [DW-1:0]        rc_b;
  logic [SW-1:0]        sl_b;
  bxf_ctl_t             ctl0;
  bxf_ctl_t             ctl2;

  // effective window side and line width
  always_comb begin
    d_cl = WIN_CMP_W'(window_size);
    if (d_cl < WIN_CMP_W'(WIN_MIN)) begin
      d_cl = WIN_CMP_W'(WIN_MIN);
    end else if (d_cl > WIN_CMP_W'(MAX_WINDOW)) begin
      d_cl = WIN_CMP_W'(MAX_WINDOW);
    end
    if (!d_cl[0]) begin
      d_cl = d_cl - 1'b1;
    end
    d_eff = d_cl[DW-1:0];
    dm1   = d_eff - 1'b1;

    w_cl = WID_CMP_W'(line_width);
    if (w_cl == '0) begin
      w_cl = WID_CMP_W'(1);
    end else if (w_cl > WID_CMP_W'(MAX_WIDTH)) begin
      w_cl = WID_CMP_W'(MAX_WIDTH);
    end
    w_eff = w_cl[CW:0];
  end

  // position of the incoming beat and counter advance
  always_comb begin
    cc_b = frame_start ? '0 : column_count;
    if ({1'b0, cc_b} >= w_eff) begin
      cc_b = '0;
    end
    rc_b = frame_start ? '0 : row_count;
    sl_b = frame_start ? '0 : slot_ptr;
    if (DW'(sl_b) >= dm1) begin
      sl_b = '0;
    end

    ctl0.valid     = accept;
    ctl0.first_row = (rc_b == '0);
    ctl0.full      = (rc_b >= dm1);
    ctl0.col0      = (cc_b == '0);
    ctl0.last      = ({1'b0, cc_b} == w_eff - 1'b1);
    ctl0.emit      = ctl0.full && ({1'b0, cc_b} >= (CW+1)'(dm1));

    col  = cc_b;
    slot = sl_b;

    column_count_next = column_count;
    row_count_next    = row_count;
    slot_ptr_next     = slot_ptr;
    if (accept) begin
      if (ctl0.last) begin
        column_count_next = '0;
        row_count_next    = (rc_b < dm1) ? rc_b + 1'b1 : rc_b;
        slot_ptr_next     = (DW'(sl_b) + 1'b1 >= dm1) ? '0 : sl_b + 1'b1;
      end else begin
        column_count_next = cc_b + 1'b1;
        row_count_next    = rc_b;
        slot_ptr_next     = sl_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WS_RESET;
      line_width   <= LW_RESET;
      column_count <= '0;
      row_count    <= '0;
      slot_ptr     <= '0;
      ctl1         <= '0;
      ctl2         <= '0;
      ctl3         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (bxf_reg_t'(cfg_index))
          REG_WINDOW_SIZE: window_size <= cfg_data[WS_W-1:0];
          REG_LINE_WIDTH:  line_width  <= cfg_data[LW_W-1:0];
        endcase
        // any register write restarts the stream
        column_count <= '0;
        row_count    <= '0;
        slot_ptr     <= '0;
      end else begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        slot_ptr     <= slot_ptr_next;
      end
      if (adv) begin
        ctl1 <= ctl0;
        ctl2 <= ctl1;
        ctl3 <= ctl2;
      end
    end
  end

  always_ff @(posedge clk) begin
    recip <= recip_for(d_cl);
  end

  a_col_in_line: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < w_eff)
    else $error("column counter beyond line width");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    DW'(slot_ptr) < dm1)
    else $error("line store slot beyond window");

  a_row_saturates: assert property (@(posedge clk) disable iff (rst)
    row_count <= dm1)
    else $error("row counter past window height");

endmodule

// ----- hw/rtl/bxf_lane.sv -----
// ----------------------------------------------------------------------------
// bxf_lane
// One color channel: line store, column sums, horizontal window and divide.
// ----------------------------------------------------------------------------
module bxf_lane import bxf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int SW  = $clog2(MAX_WINDOW - 1),
  localparam int DW  = $clog2(MAX_WINDOW + 1),
  localparam int WIW = $clog2(MAX_WINDOW),
  localparam int CSW = $clog2(MAX_WINDOW * PIX_MAX + 1),
  localparam int RSW = $clog2(MAX_WINDOW * MAX_WINDOW * PIX_MAX + 1)
) (
  input  logic               clk,
  input  logic               adv,
  input  logic [PIX_W-1:0]   pix,
  input  logic [CW-1:0]      col,
  input  logic [SW-1:0]      slot,
  input  bxf_ctl_t           ctl1,
  input  logic [DW-1:0]      dm1,
  input  logic [RECIP_W-1:0] recip,
  output logic [PIX_W-1:0]   mean
);

  logic [PIX_W-1:0]       ls_mem [MAX_WINDOW-1][MAX_WIDTH];
  logic [CSW-1:0]         cs_mem [MAX_WIDTH];
  logic [PIX_W-1:0]       pix1;
  logic [PIX_W-1:0]       ls_rd;
  logic [CSW-1:0]         cs_rd;
  logic [CW-1:0]          col1;
  logic [SW-1:0]          slot1;
  logic [CSW-1:0]         prior;
  logic [CSW-1:0]         old;
  logic [CSW-1:0]         vsum;
  logic [CSW-1:0]         cs_new;
  logic [CSW-1:0]         win [MAX_WINDOW];
  logic [RSW-1:0]         row_sum;
  logic [RSW-1:0]         rs_base;
  logic [RSW-1:0]         tap;
  logic [RSW-1:0]         rs_new;
  logic [RSW-1:0]         sum2;
  logic [RSW+RECIP_W-1:0] prod;

  // read side, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      pix1  <= pix;
      col1  <= col;
      slot1 <= slot;
      cs_rd <= cs_mem[col];
      ls_rd <= ls_mem[slot][col];
    end
  end

  // write back once the beat has its column sum
  always_ff @(posedge clk) begin
    if (adv && ctl1.valid) begin
      cs_mem[col1]        <= cs_new;
      ls_mem[slot1][col1] <= pix1;
    end
  end

  always_comb begin
    prior   = ctl1.first_row ? '0 : cs_rd;
    old     = ctl1.full ? CSW'(ls_rd) : '0;
    vsum    = prior + CSW'(pix1);
    cs_new  = vsum - old;
    // window restarts at the first column of each row
    rs_base = ctl1.col0 ? '0 : row_sum;
    tap     = ctl1.col0 ? '0 : RSW'(win[dm1[WIW-1:0]]);
    rs_new  = rs_base + RSW'(vsum) - tap;
  end

  always_ff @(posedge clk) begin
    if (adv && ctl1.valid) begin
      row_sum <= rs_new;
      win[0]  <= vsum;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        win[i] <= ctl1.col0 ? '0 : win[i-1];
      end
    end
  end

  // divide by d*d through the reciprocal
  always_ff @(posedge clk) begin
    if (adv) begin
      sum2 <= rs_new;
      prod <= sum2 * recip;
    end
  end

  assign mean = prod[RECIP_SHIFT +: PIX_W];

endmodule

// ----- hw/rtl/bxf_merge.sv -----
// ----------------------------------------------------------------------------
// bxf_merge
// Packs the lane means into one result beat, with an output and skid register.
// ----------------------------------------------------------------------------
module bxf_merge import bxf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [PORT_CH-1:0][PIX_W-1:0] mean_in,
  input  logic                          last_in,
  output logic                          ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [PORT_CH*PIX_W-1:0]      m_tdata,
  output logic                          m_tlast
);

  logic [PORT_CH*PIX_W-1:0] skid_data;
  logic                     skid_last;
  logic                     skid_valid;
  logic                     take;

  assign take  = m_tvalid & m_tready;
  assign ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= push;
        end
      end else if (!m_tvalid) begin
        m_tvalid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      m_tdata <= skid_data;
      m_tlast <= skid_last;
    end else if (push && (take || !m_tvalid)) begin
      m_tdata <= mean_in;
      m_tlast <= last_in;
    end
    // output held and not taken: the new beat parks in the skid
    if (push && m_tvalid && !take) begin
      skid_data <= mean_in;
      skid_last <= last_in;
    end
  end

endmodule

// ----- hw/rtl/box_filter_mean_rgb_top.sv -----
// ----------------------------------------------------------------------------
// box_filter_mean_rgb_top
// Streaming d-by-d box mean over three-channel 8-bit pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives the truncated window mean of each
// channel for every pixel whose full window lies inside the frame. The
// rate is set by the per-lane line store and column sum memories, each
// read and written once per cycle; the running row sum closes its loop
// through one register. Results leave through an output register backed
// by a skid register, so input stalls only when two results are waiting.
// Stores hold no defined value until a frame writes them and need no
// clearing after reset. A register write restarts the stream; the user
// must make it only while no pixel is in flight, unchecked by the block.
module box_filter_mean_rgb_top import bxf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [PORT_CH*PIX_W-1:0] s_tdata,   // chan0, chan1, chan2
  input  logic                     s_tuser,   // frame_start
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [PORT_CH*PIX_W-1:0] m_tdata,   // mean0, mean1, mean2
  output logic                     m_tlast    // row_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = $clog2(MAX_WINDOW - 1);
  localparam int DW = $clog2(MAX_WINDOW + 1);

  logic                          adv;
  logic                          accept;
  logic                          push;
  logic [CW-1:0]                 col;
  logic [SW-1:0]                 slot;
  logic [DW-1:0]                 dm1;
  logic [RECIP_W-1:0]            recip;
  bxf_ctl_t                      ctl1;
  bxf_ctl_t                      ctl3;
  logic [PIX_W-1:0]              lane_mean [CHANNELS];
  logic [PORT_CH-1:0][PIX_W-1:0] port_mean;

  assign s_tready = adv;
  assign accept   = s_tvalid & adv;
  assign push     = adv & ctl3.valid & ctl3.emit;

  bxf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .frame_start(s_tuser),
    .adv        (adv),
    .col        (col),
    .slot       (slot),
    .dm1        (dm1),
    .recip      (recip),
    .ctl1       (ctl1),
    .ctl3       (ctl3)
  );

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic [PIX_W-1:0] lane_pix;
    if (ch < PORT_CH) begin : g_in
      assign lane_pix = s_tdata[ch*PIX_W +: PIX_W];
    end else begin : g_zero
      assign lane_pix = '0;
    end

    bxf_lane #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_WINDOW(MAX_WINDOW)
    ) u_lane (
      .clk  (clk),
      .adv  (adv),
      .pix  (lane_pix),
      .col  (col),
      .slot (slot),
      .ctl1 (ctl1),
      .dm1  (dm1),
      .recip(recip),
      .mean (lane_mean[ch])
    );
  end

  for (genvar ch = 0; ch < PORT_CH; ch++) begin : g_port
    if (ch < CHANNELS) begin : g_used
      assign port_mean[ch] = lane_mean[ch];
    end else begin : g_unused
      assign port_mean[ch] = '0;
    end
  end

  bxf_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .mean_in (port_mean),
    .last_in (ctl3.last),
    .ready   (adv),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming RGB box mean filter.
// ----------------------------------------------------------------------------
// A short table of hand-picked beats runs first: tiny 3x3 frames with flat
// content whose means can be read at a glance, a missing frame start and a
// frame start in the middle of a row. Random phases follow, each under its
// own window size and line width, including values outside the legal range.
// Every accepted pixel goes through a local
// predictor of the column and row sums. Every output beat is compared with
// the oldest pending mean. Both stream sides idle at random, except in a calm phase.
module tb;
  import bxf_pkg::*;

  localparam int LIMIT         = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT      = 23;
  localparam int NUM_PHASES    = 11;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       fs;
  } pixel_t;

  typedef struct packed {
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
    logic       last;
  } mean_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    bxf_reg_t         idx;
    logic [CFG_W-1:0] val;
    pixel_t           px;
    logic             typed;
    mean_t            want;
  } step_row_t;

  typedef struct packed {
    logic [WS_W-1:0] ws;
    logic [LW_W-1:0] lw;
    logic [15:0]     quota;
    logic            calm;
    logic            hold;
  } phase_t;

  localparam pixel_t PX_NONE  = '0;
  localparam mean_t  NO_MEAN  = '0;
  localparam pixel_t WHITE    = '{8'd255, 8'd255, 8'd255, 1'b0};
  localparam pixel_t WHITE_FS = '{8'd255, 8'd255, 8'd255, 1'b1};
  localparam pixel_t MIX      = '{8'd0, 8'd255, 8'd128, 1'b0};
  localparam pixel_t MIX_FS   = '{8'd0, 8'd255, 8'd128, 1'b1};

  // 3x3 window on 3-pixel rows: the ninth pixel of each frame closes a window
  localparam step_row_t DIRECTED [25] = '{
    '{ROW_CFG, REG_LINE_WIDTH,  12'd3, PX_NONE, 1'b0, NO_MEAN},
    '{ROW_CFG, REG_WINDOW_SIZE, 12'd3, PX_NONE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE_FS, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, WHITE, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX_FS, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, MIX, 1'b1, '{8'd0, 8'd255, 8'd128, 1'b1}},
    // no frame start: the window keeps sliding into a fourth row
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, '{8'd1, 8'd2, 8'd3, 1'b0}, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, '{8'd200, 8'd100, 8'd50, 1'b0}, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, '{8'd17, 8'd34, 8'd68, 1'b0}, 1'b0, NO_MEAN},
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, '{8'd9, 8'd9, 8'd9, 1'b0}, 1'b0, NO_MEAN},
    // frame start in the middle of a row
    '{ROW_PIX, REG_WINDOW_SIZE, 12'd0, '{8'd90, 8'd91, 8'd92, 1'b1}, 1'b0, NO_MEAN}
  };

  // window 0/2/6/10/15 and width 0/4095 land on the clamped settings
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{4'd3,  12'd11,   16'd220, 1'b0, 1'b0},
    '{4'd11, 12'd11,   16'd220, 1'b0, 1'b0},
    '{4'd5,  12'd16,   16'd200, 1'b0, 1'b1},
    '{4'd7,  12'd23,   16'd200, 1'b1, 1'b0},
    '{4'd0,  12'd0,    16'd30,  1'b0, 1'b0},
    '{4'd6,  12'd12,   16'd150, 1'b0, 1'b0},
    '{4'd15, 12'd13,   16'd200, 1'b0, 1'b0},
    '{4'd7,  12'd5,    16'd40,  1'b0, 1'b0},
    '{4'd2,  12'd4095, 16'd100, 1'b0, 1'b0},
    '{4'd10, 12'd19,   16'd150, 1'b0, 1'b0},
    '{4'd9,  12'd14,   16'd150, 1'b0, 1'b0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  bxf_reg_t                 cfg_index = REG_WINDOW_SIZE;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [PORT_CH*PIX_W-1:0] s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [PORT_CH*PIX_W-1:0] m_tdata;
  logic                     m_tlast;

  // predictor state
  logic [WS_W-1:0] ws_reg = WS_RESET;
  logic [LW_W-1:0] lw_reg = LW_RESET;
  logic [7:0]      line_mem [MAX_WINDOW_DEF-1][MAX_WIDTH_DEF][3];
  int unsigned     col_acc [MAX_WIDTH_DEF][3];
  int unsigned     col_win [MAX_WINDOW_DEF][3];
  int unsigned     row_acc [3];
  int unsigned     col_pos = 0;
  int unsigned     rows_seen = 0;
  int unsigned     line_slot = 0;

  mean_t pend_means [$];
  int    mismatches = 0;
  int    cycles = 0;
  logic  no_idle = 1'b0;

  box_filter_mean_rgb_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  function automatic int unsigned eff_win();
    int unsigned d;
    d = ws_reg;
    if (d < WIN_MIN) d = WIN_MIN;
    if (d > MAX_WINDOW_DEF) d = MAX_WINDOW_DEF;
    if (d % 2 == 0) d = d - 1;
    return d;
  endfunction

  function automatic int unsigned eff_wid();
    int unsigned w;
    w = lw_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic void restart_counts();
    col_pos = 0;
    rows_seen = 0;
    line_slot = 0;
  endfunction

  // advance the column/row sums by one pixel, return the mean if a window closes
  function automatic void box_mean_step(input pixel_t p, output logic hit, output mean_t r);
    int unsigned d, w, c, ch, i, prior, drop, vsum, area;
    int unsigned px [3];
    d = eff_win();
    w = eff_wid();
    hit = 1'b0;
    r = '0;
    if (p.fs) restart_counts();
    if (col_pos >= w) col_pos = 0;
    if (line_slot >= d - 1) line_slot = 0;
    c = col_pos;
    px[0] = p.c0;
    px[1] = p.c1;
    px[2] = p.c2;
    if (c == 0) begin
      for (i = 0; i < MAX_WINDOW_DEF; i++) begin
        for (ch = 0; ch < 3; ch++) col_win[i][ch] = 0;
      end
      for (ch = 0; ch < 3; ch++) row_acc[ch] = 0;
    end
    for (ch = 0; ch < 3; ch++) begin
      prior = (rows_seen == 0) ? 0 : col_acc[c][ch];
      drop = (rows_seen >= d - 1) ? line_mem[line_slot][c][ch] : 0;
      vsum = prior + px[ch];
      col_acc[c][ch] = vsum - drop;
      line_mem[line_slot][c][ch] = px[ch][7:0];
      row_acc[ch] = row_acc[ch] + vsum - col_win[d - 1][ch];
      for (i = MAX_WINDOW_DEF - 1; i > 0; i--) col_win[i][ch] = col_win[i - 1][ch];
      col_win[0][ch] = vsum;
    end
    if (rows_seen >= d - 1 && c >= d - 1) begin
      area = d * d;
      r.m0 = 8'(row_acc[0] / area);
      r.m1 = 8'(row_acc[1] / area);
      r.m2 = 8'(row_acc[2] / area);
      r.last = (c == w - 1);
      hit = 1'b1;
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      if (rows_seen < d - 1) rows_seen++;
      line_slot++;
      if (line_slot >= d - 1) line_slot = 0;
    end
  endfunction

  function automatic logic idle_roll();
    return !no_idle && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic pixel_t make_pixel(input int unsigned mode, input logic fs);
    pixel_t p;
    case (mode)
      0: p = '{8'd255, 8'd255, 8'd255, fs};
      1: p = '{8'd0, 8'd0, 8'd0, fs};
      2: p = '{8'($urandom_range(1) * 255), 8'($urandom_range(1) * 255),
               8'($urandom_range(1) * 255), fs};
      default: p = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), fs};
    endcase
    return p;
  endfunction

  // called at a rising edge; returns at the edge where the beat was taken
  task automatic send_pixel(input pixel_t p, input logic typed, input mean_t want);
    logic  took, hit;
    mean_t got;
    took = 1'b0;
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p.c2, p.c1, p.c0};
    s_tuser  <= p.fs;
    while (!took) begin
      @(negedge clk);
      if (s_tready) begin
        took = 1'b1;
        box_mean_step(p, hit, got);
        if (typed) pend_means.push_back(want);
        else if (hit) pend_means.push_back(got);
      end
      @(posedge clk);
    end
  endtask

  task automatic hold_for_means();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pend_means.size() != 0);
  endtask

  // pixels that close no window may still be in flight: let the pipe drain
  task automatic settle();
    hold_for_means();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bxf_reg_t idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_SIZE) ws_reg = val[WS_W-1:0];
    else lw_reg = val[LW_W-1:0];
    restart_counts();
  endtask

  task automatic run_frame(input logic hold_mid, input int unsigned budget,
                           output int unsigned sent);
    int unsigned d, w, rows, total, k, mode;
    logic        skip_fs;
    d = eff_win();
    w = eff_wid();
    rows = (w > 64) ? d : $urandom_range(d + 3, d);
    total = rows * w;
    skip_fs = ($urandom_range(19) == 0);
    // now and then cut the frame short so the next frame start lands mid-row
    if (w <= 64 && total > 1 && $urandom_range(9) == 0) total = $urandom_range(total - 1, 1);
    // the phase ends where its pixel budget runs out
    if (total > budget) total = budget;
    mode = $urandom_range(9);
    for (k = 0; k < total; k++) begin
      if (hold_mid && k == total / 2) hold_for_means();
      send_pixel(make_pixel(mode, k == 0 && !skip_fs), 1'b0, NO_MEAN);
    end
    sent = total;
  endtask

  task automatic report_miss(input string what, input mean_t want);
    if (mismatches < 10) begin
      $display("mismatch (%s) at %0t: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
               what, $realtime, want.m0, want.m1, want.m2, want.last,
               m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
    end
    mismatches++;
  endtask

  // sink side: a beat seen at the falling edge is taken at the next rising edge
  always @(negedge clk) begin : watch_means
    mean_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pend_means.size() == 0) begin
        report_miss("beat with nothing pending", NO_MEAN);
      end else begin
        want = pend_means.pop_front();
        if (m_tdata[7:0] !== want.m0) report_miss("mean0", want);
        if (m_tdata[15:8] !== want.m1) report_miss("mean1", want);
        if (m_tdata[23:16] !== want.m2) report_miss("mean2", want);
        if (m_tlast !== want.last) report_miss("row_last", want);
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("[box_filter_mean_rgb_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned sent, n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_CFG) write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      else send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_WINDOW_SIZE, CFG_W'(PHASES[ph].ws));
      write_reg(REG_LINE_WIDTH, PHASES[ph].lw);
      no_idle = PHASES[ph].calm;
      sent = 0;
      while (sent < PHASES[ph].quota) begin
        run_frame(PHASES[ph].hold && sent == 0, PHASES[ph].quota - sent, n);
        sent += n;
      end
      no_idle = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("[box_filter_mean_rgb_top] OK");
    end else begin
      $display("[box_filter_mean_rgb_top] ERROR");
    end
    $finish;
  end

endmodule
